>>> rtl/shrp_pkg.sv
// Shared types, constants and the report ID table of the sensor hub report parser.
`default_nettype none

package shrp_pkg;

   // Default buffer depth in bytes and the bytes the decoder looks at.
   localparam int MAX_REPORT_BYTES_DEF = 16;
   localparam int FRAME_BYTES          = 16;

   // Result queue depth and the width of its fill level.
   localparam int OQ_DEPTH = 4;
   localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
   localparam int OQ_LVL_W = $clog2(OQ_DEPTH + 1);

   // Delay ticks are 100 us each.
   localparam int TICK_US = 100;

   // Result status codes.
   localparam logic [1:0] ST_DECODED = 2'd0;
   localparam logic [1:0] ST_HEADER  = 2'd1;
   localparam logic [1:0] ST_UNKNOWN = 2'd2;

   // Payload layout of a report.
   typedef enum logic [3:0] {
      KIND_UNKNOWN,
      KIND_VEC,
      KIND_VEC2,
      KIND_QUAT,
      KIND_QACC,
      KIND_RAWV,
      KIND_STEPC,
      KIND_W32,
      KIND_B8,
      KIND_H16,
      KIND_HDR
   } kind_type;

   typedef struct packed {
      logic [4:0] len;
      kind_type   kind;
   } id_entry_type;

   // Report event handed from the byte collector to the decoder.
   typedef struct packed {
      logic       valid;
      logic       err;
      logic [7:0] id;
      kind_type   kind;
   } event_type;

   // One result word.
   typedef struct packed {
      logic [7:0]  sensor_code;
      logic [1:0]  status;
      logic [7:0]  sequence_res;
      logic [1:0]  accuracy;
      logic [20:0] delay_usec;
      logic [38:0] stamp_offset_usec;
      logic [15:0] val_x;
      logic [15:0] val_y;
      logic [15:0] val_z;
      logic [15:0] val_w;
      logic [31:0] wide_word;
      logic        last;
   } rsp_type;

   // Up to two result words produced for one report event.
   typedef struct packed {
      logic [1:0] n;
      rsp_type    r0;
      rsp_type    r1;
   } push_type;

   // Report ID to length and layout. A length of zero marks an unknown ID.
   function automatic id_entry_type id_lookup(logic [7:0] id);
      id_entry_type e;
      begin
         unique case (id)
            8'd1, 8'd2, 8'd3, 8'd4, 8'd6:  e = '{len: 5'd10, kind: KIND_VEC};
            8'd5, 8'd9, 8'd40:             e = '{len: 5'd14, kind: KIND_QACC};
            8'd7, 8'd15:                   e = '{len: 5'd16, kind: KIND_VEC2};
            8'd8, 8'd41:                   e = '{len: 5'd12, kind: KIND_QUAT};
            8'd10, 8'd11, 8'd27:           e = '{len: 5'd8,  kind: KIND_HDR};
            8'd12, 8'd13, 8'd14, 8'd26, 8'd28,
            8'd31, 8'd32, 8'd33, 8'd34, 8'd35:
                                           e = '{len: 5'd6,  kind: KIND_HDR};
            8'd16:                         e = '{len: 5'd5,  kind: KIND_B8};
            8'd17:                         e = '{len: 5'd12, kind: KIND_STEPC};
            8'd18, 8'd25:                  e = '{len: 5'd6,  kind: KIND_H16};
            8'd19:                         e = '{len: 5'd6,  kind: KIND_B8};
            8'd20, 8'd21, 8'd22:           e = '{len: 5'd16, kind: KIND_RAWV};
            8'd24:                         e = '{len: 5'd8,  kind: KIND_W32};
            8'd30:                         e = '{len: 5'd16, kind: KIND_HDR};
            8'd42:                         e = '{len: 5'd14, kind: KIND_HDR};
            default:                       e = '{len: 5'd0,  kind: KIND_UNKNOWN};
         endcase
         return e;
      end
   endfunction

endpackage

`default_nettype wire

>>> rtl/shrp_if.sv
// Valid/ready channel interfaces for report bytes in and decoded results out.
`default_nettype none

interface shrp_req_if;
   logic               valid;
   logic               ready;
   logic [7:0]         data_byte;
   logic               start_req;
   logic signed [31:0] ref_delta_ticks;

   modport source (output valid, data_byte, start_req, ref_delta_ticks, input ready);
   modport sink   (input valid, data_byte, start_req, ref_delta_ticks, output ready);
endinterface

interface shrp_rsp_if;
   logic               valid;
   logic               ready;
   logic [7:0]         sensor_code;
   logic [1:0]         status;
   logic [7:0]         sequence_res;
   logic [1:0]         accuracy;
   logic [20:0]        delay_usec;
   logic signed [38:0] stamp_offset_usec;
   logic signed [15:0] val_x;
   logic signed [15:0] val_y;
   logic signed [15:0] val_z;
   logic signed [15:0] val_w;
   logic [31:0]        wide_word;
   logic               last;

   modport source (output valid, sensor_code, status, sequence_res, accuracy, delay_usec,
                   stamp_offset_usec, val_x, val_y, val_z, val_w, wide_word, last,
                   input ready);
   modport sink   (input valid, sensor_code, status, sequence_res, accuracy, delay_usec,
                   stamp_offset_usec, val_x, val_y, val_z, val_w, wide_word, last,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/shrp_collect.sv
// Byte collector: report buffer, byte count and the report event register.
`default_nettype none

module shrp_collect #(
   parameter int MAX_REPORT_BYTES = shrp_pkg::MAX_REPORT_BYTES_DEF
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      accept,
   input  wire logic [7:0]                                data_byte,
   input  wire logic                                      start_req,
   input  wire logic [31:0]                               ref_delta_ticks,
   output logic [shrp_pkg::FRAME_BYTES-1:0][7:0]          frame,
   output logic [31:0]                                    delta_hold,
   output shrp_pkg::event_type                            ev
);

   localparam int IDX_W = $clog2(MAX_REPORT_BYTES);

   logic [7:0]             rbuf_ff [MAX_REPORT_BYTES];
   logic [4:0]             count_ff, count_in;
   logic [4:0]             exp_ff, exp_in;
   logic [31:0]            hold_ff, hold_in;
   logic                   idle_ff, idle_in;
   shrp_pkg::kind_type     kind_ff, kind_in;
   shrp_pkg::event_type    ev_ff, ev_in;
   shrp_pkg::id_entry_type lk;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_idx;

   assign lk = shrp_pkg::id_lookup(data_byte);

   always_comb begin
      count_in = count_ff;
      exp_in   = exp_ff;
      hold_in  = hold_ff;
      idle_in  = idle_ff;
      kind_in  = kind_ff;
      ev_in    = '0;
      wr_en    = 1'b0;
      wr_idx   = count_ff[IDX_W-1:0];
      if (accept) begin
         if (start_req) begin
            if (lk.len == 5'd0) begin
               // Unknown ID reports at once and the rest of the report is skipped.
               ev_in.valid = 1'b1;
               ev_in.err   = 1'b1;
               ev_in.id    = data_byte;
               idle_in     = 1'b1;
               count_in    = 5'd0;
               exp_in      = 5'd0;
            end else begin
               wr_en    = 1'b1;
               wr_idx   = '0;
               count_in = 5'd1;
               exp_in   = lk.len;
               hold_in  = ref_delta_ticks;
               idle_in  = 1'b0;
               kind_in  = lk.kind;
            end
         end else if (!idle_ff) begin
            wr_en    = (int'(count_ff) < MAX_REPORT_BYTES);
            count_in = count_ff + 5'd1;
            if (count_in == exp_ff) begin
               idle_in     = 1'b1;
               ev_in.valid = 1'b1;
               ev_in.kind  = kind_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         exp_ff   <= '0;
         hold_ff  <= '0;
         idle_ff  <= 1'b1;
         kind_ff  <= shrp_pkg::KIND_UNKNOWN;
         ev_ff    <= '0;
      end else begin
         count_ff <= count_in;
         exp_ff   <= exp_in;
         hold_ff  <= hold_in;
         idle_ff  <= idle_in;
         kind_ff  <= kind_in;
         ev_ff    <= ev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rbuf_ff[wr_idx] <= data_byte;
      end
   end

   for (genvar i = 0; i < shrp_pkg::FRAME_BYTES; i++) begin : g_frame
      assign frame[i] = rbuf_ff[i];
   end

   assign delta_hold = hold_ff;
   assign ev         = ev_ff;

`ifndef SYNTHESIS
   // Every report event leaves the collector waiting for the next start byte.
   a_event_idle: assert property (@(posedge clock) disable iff (reset)
      ev_ff.valid |-> idle_ff)
      else $error("report event while collector still inside a report");
`endif

endmodule

`default_nettype wire

>>> rtl/shrp_decode.sv
// Report decoder: header fields, delay arithmetic and payload word extraction.
`default_nettype none

module shrp_decode (
   input  wire shrp_pkg::event_type                  ev,
   input  wire logic [shrp_pkg::FRAME_BYTES-1:0][7:0] frame,
   input  wire logic [31:0]                          delta_hold,
   output shrp_pkg::push_type                        push
);

   logic [13:0]        ticks;
   logic signed [32:0] tick_sum;
   logic signed [39:0] off_prod;
   shrp_pkg::rsp_type  base;

   // Delay is status bits 7:2 above byte 3, in 100 us ticks.
   assign ticks    = {frame[2][7:2], frame[3]};
   assign tick_sum = $signed({19'd0, ticks}) + $signed({delta_hold[31], delta_hold});
   assign off_prod = 40'(tick_sum) * 40'sd100;

   always_comb begin
      base                   = '0;
      base.sensor_code       = frame[0];
      base.sequence_res      = frame[1];
      base.accuracy          = frame[2][1:0];
      base.delay_usec        = 21'({7'd0, ticks} * 21'(shrp_pkg::TICK_US));
      base.stamp_offset_usec = off_prod[38:0];
      base.last              = 1'b1;
   end

   always_comb begin
      push = '0;
      if (ev.valid) begin
         push.n = 2'd1;
         if (ev.err) begin
            push.r0.sensor_code = ev.id;
            push.r0.status      = shrp_pkg::ST_UNKNOWN;
            push.r0.last        = 1'b1;
         end else begin
            push.r0 = base;
            push.r1 = base;
            unique case (ev.kind)
               shrp_pkg::KIND_VEC: begin
                  push.r0.val_x = {frame[5], frame[4]};
                  push.r0.val_y = {frame[7], frame[6]};
                  push.r0.val_z = {frame[9], frame[8]};
               end
               shrp_pkg::KIND_VEC2: begin
                  // Uncalibrated sensors: raw vector, then the bias vector.
                  push.n         = 2'd2;
                  push.r0.val_x  = {frame[5], frame[4]};
                  push.r0.val_y  = {frame[7], frame[6]};
                  push.r0.val_z  = {frame[9], frame[8]};
                  push.r0.last   = 1'b0;
                  push.r1.val_x  = {frame[11], frame[10]};
                  push.r1.val_y  = {frame[13], frame[12]};
                  push.r1.val_z  = {frame[15], frame[14]};
               end
               shrp_pkg::KIND_QUAT, shrp_pkg::KIND_QACC: begin
                  push.r0.val_x = {frame[5], frame[4]};
                  push.r0.val_y = {frame[7], frame[6]};
                  push.r0.val_z = {frame[9], frame[8]};
                  push.r0.val_w = {frame[11], frame[10]};
                  if (ev.kind == shrp_pkg::KIND_QACC) begin
                     push.r0.wide_word = {16'd0, frame[13], frame[12]};
                  end
               end
               shrp_pkg::KIND_RAWV: begin
                  push.r0.val_x     = {frame[5], frame[4]};
                  push.r0.val_y     = {frame[7], frame[6]};
                  push.r0.val_z     = {frame[9], frame[8]};
                  push.r0.wide_word = {frame[15], frame[14], frame[13], frame[12]};
               end
               shrp_pkg::KIND_STEPC: begin
                  // Step counter: latency word, then the step count.
                  push.n            = 2'd2;
                  push.r0.wide_word = {frame[7], frame[6], frame[5], frame[4]};
                  push.r0.last      = 1'b0;
                  push.r1.wide_word = {frame[11], frame[10], frame[9], frame[8]};
               end
               shrp_pkg::KIND_W32: begin
                  push.r0.wide_word = {frame[7], frame[6], frame[5], frame[4]};
               end
               shrp_pkg::KIND_B8: begin
                  push.r0.wide_word = {24'd0, frame[4]};
               end
               shrp_pkg::KIND_H16: begin
                  push.r0.wide_word = {16'd0, frame[5], frame[4]};
               end
               shrp_pkg::KIND_HDR: begin
                  push.r0.status = shrp_pkg::ST_HEADER;
               end
               default: begin
                  push.r0.status = shrp_pkg::ST_DECODED;
               end
            endcase
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/shrp_outq.sv
// Result queue: holds decoded words until the result channel takes them.
`default_nettype none

module shrp_outq (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire shrp_pkg::push_type              push,
   output logic [shrp_pkg::OQ_LVL_W-1:0]        level,
   shrp_rsp_if.source                           rsp
);

   localparam int PTR_W = shrp_pkg::OQ_PTR_W;
   localparam int LVL_W = shrp_pkg::OQ_LVL_W;

   shrp_pkg::rsp_type q_ff [shrp_pkg::OQ_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]  wr_next;
   logic [LVL_W-1:0]  level_ff, level_in;
   logic              pop;
   shrp_pkg::rsp_type head;

   assign pop       = rsp.valid && rsp.ready;
   assign wr_next   = wr_ptr_ff + PTR_W'(1);
   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push.n);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign level_in  = level_ff + LVL_W'(push.n) - LVL_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.n != 2'd0) begin
         q_ff[wr_ptr_ff] <= push.r0;
      end
      if (push.n == 2'd2) begin
         q_ff[wr_next] <= push.r1;
      end
   end

   assign head                  = q_ff[rd_ptr_ff];
   assign level                 = level_ff;
   assign rsp.valid             = (level_ff != '0);
   assign rsp.sensor_code       = head.sensor_code;
   assign rsp.status            = head.status;
   assign rsp.sequence_res      = head.sequence_res;
   assign rsp.accuracy          = head.accuracy;
   assign rsp.delay_usec        = head.delay_usec;
   assign rsp.stamp_offset_usec = head.stamp_offset_usec;
   assign rsp.val_x             = head.val_x;
   assign rsp.val_y             = head.val_y;
   assign rsp.val_z             = head.val_z;
   assign rsp.val_w             = head.val_w;
   assign rsp.wide_word         = head.wide_word;
   assign rsp.last              = head.last;

`ifndef SYNTHESIS
   // The queue never holds more words than it has entries.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LVL_W'(shrp_pkg::OQ_DEPTH))
      else $error("result queue overflow");

   // A two word push only arrives when two entries are free.
   a_pair_room: assert property (@(posedge clock) disable iff (reset)
      (push.n == 2'd2) |-> (level_ff <= LVL_W'(shrp_pkg::OQ_DEPTH - 2)))
      else $error("two word push without room");

   // Two words in a push: only the second one closes the report.
   a_pair_last: assert property (@(posedge clock) disable iff (reset)
      (push.n == 2'd2) |-> (!push.r0.last && push.r1.last))
      else $error("two word report with wrong last flags");
`endif

endmodule

`default_nettype wire

>>> rtl/sensor_hub_report_parser_unit.sv
// Top level of the sensor hub input report parser.
`default_nettype none

// Channel  Dir  Word                                         Accepted when
// req_port in   report byte, start flag, timebase delta      valid && ready
// rsp_port out  one decoded result, last marks report end    valid && ready
//
// The parser takes one report byte per cycle, back to back, while the result queue
// has room. A result for the byte that completes its report (or the start byte of
// an unknown ID) is held first in the event register, then in the four word result
// queue, before it appears on rsp_port. Two word reports queue both words at once.
// req_port.ready drops only when the queue could not absorb the words of a byte
// already in flight plus the next one; a stalled result side then stalls input.
// Reset is synchronous; the report buffer itself is not cleared and needs none.

module sensor_hub_report_parser_unit #(
   parameter int MAX_REPORT_BYTES = shrp_pkg::MAX_REPORT_BYTES_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   shrp_req_if.sink   req_port,
   shrp_rsp_if.source rsp_port
);

   localparam int LVL_W = shrp_pkg::OQ_LVL_W;

   logic                                  accept;
   logic [shrp_pkg::FRAME_BYTES-1:0][7:0] frame;
   logic [31:0]                           delta_hold;
   shrp_pkg::event_type                   ev;
   shrp_pkg::push_type                    push;
   logic [LVL_W-1:0]                      level;

   assign accept = req_port.valid && req_port.ready;

   // Room is needed for the pending event's words and two more for this byte.
   assign req_port.ready = ((level + LVL_W'(push.n)) <= LVL_W'(shrp_pkg::OQ_DEPTH - 2));

   shrp_collect #(
      .MAX_REPORT_BYTES (MAX_REPORT_BYTES)
   ) u_collect (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .data_byte       (req_port.data_byte),
      .start_req       (req_port.start_req),
      .ref_delta_ticks (req_port.ref_delta_ticks),
      .frame           (frame),
      .delta_hold      (delta_hold),
      .ev              (ev)
   );

   shrp_decode u_decode (
      .ev         (ev),
      .frame      (frame),
      .delta_hold (delta_hold),
      .push       (push)
   );

   shrp_outq u_outq (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .level (level),
      .rsp   (rsp_port)
   );

`ifndef SYNTHESIS
   // A report event always follows an accepted byte in the previous cycle.
   a_event_cause: assert property (@(posedge clock) disable iff (reset)
      ev.valid |-> $past(accept))
      else $error("report event without an accepted byte");
`endif

endmodule

`default_nettype wire
